### design/rtce_pkg.sv
package rtce_pkg;

    typedef enum logic [1:0] {
        MODE_SET      = 2'd0,
        MODE_READ     = 2'd1,
        MODE_OVERFLOW = 2'd2,
        MODE_TICK     = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_RATE   = 1'b0,
        CFG_UPDATE = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_INT,
        ST_MUL,
        ST_DIV_FRAC,
        ST_FINISH
    } state_t;

    localparam int SEC_W     = 40;
    localparam int NS_W      = 30;
    localparam int CNT_W     = 32;
    localparam int SPAN_W    = CNT_W + 1;
    localparam int RATE_W    = 16;
    localparam int PROD_W    = RATE_W + NS_W;
    localparam int STEP_W    = 6;

    localparam logic [STEP_W-1:0] INT_STEPS  = STEP_W'(SPAN_W);
    localparam logic [STEP_W-1:0] FRAC_STEPS = STEP_W'(PROD_W);

    localparam logic [NS_W-1:0]   NS_PER_SECOND = NS_W'(1000000000);
    localparam logic [RATE_W-1:0] RATE_RESET    = RATE_W'(32000);
    localparam logic [SPAN_W-1:0] WRAP_COUNTS   = {1'b1, {CNT_W{1'b0}}};

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic long_op;
        logic out_free;
    } dp_status_t;

endpackage

### design/rtce_ctrl.sv
module rtce_ctrl
    import rtce_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_valid) begin
                    state_next = status.long_op ? ST_DIV_INT : ST_FINISH;
                end
            end
            ST_DIV_INT: begin
                if (step_reg == INT_STEPS - 1'b1) begin
                    state_next = ST_MUL;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV_FRAC;
                step_next  = '0;
            end
            ST_DIV_FRAC: begin
                if (step_reg == FRAC_STEPS - 1'b1) begin
                    state_next = ST_FINISH;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DIV_INT:  cmd.div_step = 1'b1;
            ST_MUL:      cmd.mul      = 1'b1;
            ST_DIV_FRAC: cmd.div_step = 1'b1;
            ST_FINISH:   cmd.finish   = status.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### design/rtce_datapath.sv
module rtce_datapath
    import rtce_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [RATE_W-1:0] cfg_wdata,
    input  logic [1:0]        s_mode,
    input  logic [CNT_W-1:0]  s_counter_value,
    input  logic [SEC_W-1:0]  s_set_seconds,
    input  logic [NS_W-1:0]   s_set_nanoseconds,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SEC_W-1:0]  m_time_seconds,
    output logic [NS_W-1:0]   m_time_nanoseconds,
    output logic              m_second_elapsed,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status
);

    // configuration
    logic [RATE_W-1:0] rate_reg;
    logic              update_enable_reg;

    // held time state
    logic [SEC_W-1:0]  base_s_reg;
    logic [NS_W-1:0]   base_ns_reg;
    logic [CNT_W-1:0]  snapshot_reg;
    logic              wrapped_reg;
    logic [RATE_W-1:0] tick_reg;

    // latched item
    mode_t             mode_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SEC_W-1:0]  set_s_reg;
    logic [NS_W-1:0]   set_ns_reg;

    // divider
    logic [PROD_W-1:0] quo_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [SPAN_W-1:0] whole_reg;

    // result
    logic              m_valid_reg;
    logic [SEC_W-1:0]  out_s_reg;
    logic [NS_W-1:0]   out_ns_reg;
    logic              out_flag_reg;
    logic [SEC_W-1:0]  out_s_next;
    logic [NS_W-1:0]   out_ns_next;
    logic              out_flag_next;

    logic [RATE_W-1:0] rate_eff;
    mode_t             in_mode;
    logic [CNT_W-1:0]  start;
    logic [SPAN_W-1:0] counts;
    logic [RATE_W:0]   shifted;
    logic [RATE_W:0]   diff;
    logic              ge;
    logic [NS_W:0]     ns_sum;
    logic              ns_carry;
    logic [NS_W-1:0]   calc_ns;
    logic [SEC_W-1:0]  calc_s;
    logic              set_fix;
    logic [NS_W-1:0]   load_ns;
    logic [SEC_W-1:0]  load_s;
    logic [RATE_W-1:0] tick_inc;
    logic              tick_wrap;

    assign rate_eff = (rate_reg == '0) ? RATE_W'(1) : rate_reg;
    assign in_mode  = mode_t'(s_mode);

    // after a wrap the base already covers every count up to it
    assign start  = wrapped_reg ? '0 : snapshot_reg;
    assign counts = (in_mode == MODE_OVERFLOW)
                  ? WRAP_COUNTS - {1'b0, start}
                  : {1'b0, s_counter_value - start};

    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign diff    = shifted - {1'b0, rate_eff};
    assign ge      = shifted >= {1'b0, rate_eff};

    assign ns_sum   = {1'b0, quo_reg[NS_W-1:0]} + {1'b0, base_ns_reg};
    assign ns_carry = ns_sum >= {1'b0, NS_PER_SECOND};
    assign calc_ns  = ns_carry ? NS_W'(ns_sum - {1'b0, NS_PER_SECOND}) : ns_sum[NS_W-1:0];
    assign calc_s   = base_s_reg + SEC_W'(whole_reg) + SEC_W'(ns_carry);

    assign set_fix  = set_ns_reg >= NS_PER_SECOND;
    assign load_ns  = set_fix ? set_ns_reg - NS_PER_SECOND : set_ns_reg;
    assign load_s   = set_s_reg + SEC_W'(set_fix);

    assign tick_inc  = tick_reg + 1'b1;
    assign tick_wrap = (tick_reg == '1) || (tick_inc >= rate_eff);

    assign status.long_op  = (in_mode == MODE_READ) || (in_mode == MODE_OVERFLOW);
    assign status.out_free = !m_valid_reg || m_ready;

    always_comb begin
        out_s_next    = base_s_reg;
        out_ns_next   = base_ns_reg;
        out_flag_next = 1'b0;
        case (mode_reg)
            MODE_SET: begin
                out_s_next  = load_s;
                out_ns_next = load_ns;
            end
            MODE_READ, MODE_OVERFLOW: begin
                out_s_next  = calc_s;
                out_ns_next = calc_ns;
            end
            MODE_TICK: begin
                out_flag_next = update_enable_reg && tick_wrap;
            end
            default: begin
                out_flag_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg          <= RATE_RESET;
            update_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_RATE:   rate_reg          <= cfg_wdata;
                CFG_UPDATE: update_enable_reg <= cfg_wdata[0];
                default:    rate_reg          <= rate_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= in_mode;
            cnt_reg    <= s_counter_value;
            set_s_reg  <= s_set_seconds;
            set_ns_reg <= s_set_nanoseconds;
            quo_reg    <= {counts, {(PROD_W-SPAN_W){1'b0}}};
            rem_reg    <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[PROD_W-2:0], ge};
            rem_reg <= ge ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
        end else if (cmd.mul) begin
            whole_reg <= quo_reg[SPAN_W-1:0];
            quo_reg   <= PROD_W'(rem_reg) * PROD_W'(NS_PER_SECOND);
            rem_reg   <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_s_reg   <= '0;
            base_ns_reg  <= '0;
            snapshot_reg <= '0;
            wrapped_reg  <= 1'b0;
            tick_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.finish) begin
                m_valid_reg  <= 1'b1;
                out_s_reg    <= out_s_next;
                out_ns_reg   <= out_ns_next;
                out_flag_reg <= out_flag_next;
                case (mode_reg)
                    MODE_SET: begin
                        base_s_reg   <= load_s;
                        base_ns_reg  <= load_ns;
                        snapshot_reg <= cnt_reg;
                        wrapped_reg  <= 1'b0;
                    end
                    MODE_OVERFLOW: begin
                        base_s_reg  <= calc_s;
                        base_ns_reg <= calc_ns;
                        wrapped_reg <= 1'b1;
                    end
                    MODE_TICK: begin
                        if (update_enable_reg) begin
                            tick_reg <= tick_wrap ? '0 : tick_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_time_seconds     = out_s_reg;
    assign m_time_nanoseconds = out_ns_reg;
    assign m_second_elapsed   = out_flag_reg;

endmodule

### design/rtc_counter_time_extend_unit.sv
// Extends a free-running 32-bit counter into epoch seconds and nanoseconds. Each item
// (set time, read time, counter overflow or tick) gives exactly one result item. Items
// are taken one at a time. Set and tick go from the load step straight to finish; read
// and overflow load, run 33 steps of a bit-per-cycle divider for whole seconds, one
// multiply by 10^9 and 46 divider steps for the nanosecond fraction, then finish by
// adding into the base. The shared radix-2 divider sets the length of these two. The
// result sits in an output register until taken; the next item is accepted once the
// block is back in idle. Configuration is written through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while no item is in progress (the block does not enforce
// this): index 0 is counts_per_second (0 acts as 1), index 1 is update_enable.
module rtc_counter_time_extend_unit
    import rtce_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [RATE_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [CNT_W-1:0]  s_counter_value,
    input  logic [SEC_W-1:0]  s_set_seconds,
    input  logic [NS_W-1:0]   s_set_nanoseconds,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SEC_W-1:0]  m_time_seconds,
    output logic [NS_W-1:0]   m_time_nanoseconds,
    output logic              m_second_elapsed
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    rtce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rtce_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_mode             (s_mode),
        .s_counter_value    (s_counter_value),
        .s_set_seconds      (s_set_seconds),
        .s_set_nanoseconds  (s_set_nanoseconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_time_seconds     (m_time_seconds),
        .m_time_nanoseconds (m_time_nanoseconds),
        .m_second_elapsed   (m_second_elapsed),
        .cmd                (cmd),
        .status             (status)
    );

endmodule

### tb/tb_rtc_counter_time_extend_unit.sv
module tb_rtc_counter_time_extend_unit;
    import rtce_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int STALL_CYCLES = 400;
    localparam int END_SETTLE   = 100;
    localparam int ITEM_TARGET  = 1650;

    typedef struct {
        logic [SEC_W-1:0] seconds;
        logic [NS_W-1:0]  nanoseconds;
        logic             second_elapsed;
    } time_result_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic              cfg_index;
    logic [RATE_W-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_mode;
    logic [CNT_W-1:0]  s_counter_value;
    logic [SEC_W-1:0]  s_set_seconds;
    logic [NS_W-1:0]   s_set_nanoseconds;
    logic              m_valid;
    logic              m_ready;
    logic [SEC_W-1:0]  m_time_seconds;
    logic [NS_W-1:0]   m_time_nanoseconds;
    logic              m_second_elapsed;

    // clock model state
    logic [RATE_W-1:0] rate_reg;
    logic              update_en;
    logic [SEC_W-1:0]  base_sec;
    logic [NS_W-1:0]   base_ns;
    logic [CNT_W-1:0]  snapshot;
    logic              wrapped;
    logic [15:0]       tick_cnt;

    time_result_t pending_times[$];
    time_result_t want;

    int errors;
    int items_sent;
    int results_checked;
    int cfg_writes;
    int flags_seen;
    int mode_count[4];
    int cycle_count;
    int rx_wait;
    bit rx_hold;
    bit rx_idle;
    bit tx_idle;

    rtc_counter_time_extend_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_counter_value    (s_counter_value),
        .s_set_seconds      (s_set_seconds),
        .s_set_nanoseconds  (s_set_nanoseconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_time_seconds     (m_time_seconds),
        .m_time_nanoseconds (m_time_nanoseconds),
        .m_second_elapsed   (m_second_elapsed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // adds a span of counter counts to the held base time
    function automatic void fold_counts(input logic [SPAN_W-1:0] counts,
                                        output logic [SEC_W-1:0] secs,
                                        output logic [NS_W-1:0] nsec);
        logic [63:0] rate;
        logic [63:0] whole;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] n;
        logic [63:0] sum;
        rate  = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
        whole = 64'(counts) / rate;
        rem   = 64'(counts) - whole * rate;
        frac  = (rem * 64'(NS_PER_SECOND)) / rate;
        n     = frac + 64'(base_ns);
        sum   = 64'(base_sec) + whole + n / 64'(NS_PER_SECOND);
        nsec  = NS_W'(n % 64'(NS_PER_SECOND));
        secs  = sum[SEC_W-1:0];
    endfunction

    function automatic time_result_t predict_time(input mode_t op,
                                                  input logic [CNT_W-1:0] cnt,
                                                  input logic [SEC_W-1:0] load_sec,
                                                  input logic [NS_W-1:0] load_ns);
        time_result_t r;
        logic [SEC_W-1:0] ls;
        logic [NS_W-1:0]  lns;
        logic [SPAN_W-1:0] span;
        logic [15:0] next_cnt;
        logic [16:0] eff_rate;
        r.seconds        = base_sec;
        r.nanoseconds    = base_ns;
        r.second_elapsed = 1'b0;
        ls  = load_sec;
        lns = load_ns;
        case (op)
            MODE_SET: begin
                if (lns >= NS_PER_SECOND) begin
                    lns = lns - NS_PER_SECOND;
                    ls  = ls + 1'b1;
                end
                base_sec      = ls;
                base_ns       = lns;
                snapshot      = cnt;
                wrapped       = 1'b0;
                r.seconds     = ls;
                r.nanoseconds = lns;
            end
            MODE_READ: begin
                span = {1'b0, cnt - (wrapped ? '0 : snapshot)};
                fold_counts(span, r.seconds, r.nanoseconds);
            end
            MODE_OVERFLOW: begin
                // first wrap after a set only adds the counts left up to the wrap
                span = wrapped ? WRAP_COUNTS : WRAP_COUNTS - {1'b0, snapshot};
                fold_counts(span, r.seconds, r.nanoseconds);
                base_sec = r.seconds;
                base_ns  = r.nanoseconds;
                wrapped  = 1'b1;
            end
            default: begin
                if (update_en) begin
                    next_cnt = tick_cnt + 16'd1;
                    eff_rate = (rate_reg == '0) ? 17'd1 : {1'b0, rate_reg};
                    if (tick_cnt == 16'hFFFF || {1'b0, next_cnt} >= eff_rate) begin
                        tick_cnt         = '0;
                        r.second_elapsed = 1'b1;
                    end else begin
                        tick_cnt = next_cnt;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic write_register(input cfg_index_t idx, input logic [RATE_W-1:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        if (idx == CFG_RATE) begin
            rate_reg = val;
        end else begin
            update_en = val[0];
        end
        cfg_writes++;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic send_item(input mode_t op, input logic [CNT_W-1:0] cnt,
                             input logic [SEC_W-1:0] secs, input logic [NS_W-1:0] nsec);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           = 1'b1;
        s_mode            = op;
        s_counter_value   = cnt;
        s_set_seconds     = secs;
        s_set_nanoseconds = nsec;
        do @(posedge aclk); while (!s_ready);
        pending_times.push_back(predict_time(op, cnt, secs, nsec));
        mode_count[op]++;
        items_sent++;
    endtask

    task automatic wait_idle(input int settle);
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_times.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    function automatic logic [SEC_W-1:0] rand_seconds();
        return SEC_W'({$urandom, $urandom});
    endfunction

    // mostly in range, now and then the full field width
    function automatic logic [NS_W-1:0] rand_nanoseconds();
        if ($urandom_range(0, 7) == 0) begin
            return NS_W'($urandom);
        end
        return NS_W'($urandom_range(0, 999999999));
    endfunction

    task automatic test_time_set_and_read();
        send_item(MODE_READ, 32'd0, '0, '0);
        // set with out-of-range nanoseconds at the top second: carry wraps seconds
        send_item(MODE_SET, 32'hFFFF_FFFF, {SEC_W{1'b1}}, {NS_W{1'b1}});
        send_item(MODE_READ, 32'hFFFF_FFFF, '0, '0);
        send_item(MODE_READ, 32'd0, '0, '0);
        send_item(MODE_OVERFLOW, 32'd0, '0, '0);
        send_item(MODE_READ, 32'hFFFF_FFFF, '0, '0);
        send_item(MODE_OVERFLOW, 32'h1234_5678, '0, '0);
        send_item(MODE_SET, 32'd0, {SEC_W{1'b1}}, NS_W'(999999999));
        send_item(MODE_READ, 32'hFFFF_FFFF, '0, '0);
        send_item(MODE_SET, 32'h8000_0000, '0, NS_W'(1000000000));
        send_item(MODE_OVERFLOW, '0, '0, '0);
        send_item(MODE_READ, 32'h7FFF_FFFF, '0, '0);
        send_item(MODE_TICK, 32'hFFFF_FFFF, {SEC_W{1'b1}}, {NS_W{1'b1}});
        wait_idle(4);
    endtask

    task automatic test_rate_extremes();
        write_register(CFG_RATE, 16'd0);
        send_item(MODE_READ, 32'd5, '0, '0);
        send_item(MODE_OVERFLOW, '0, '0, '0);
        wait_idle(4);
        write_register(CFG_RATE, 16'hFFFF);
        send_item(MODE_READ, 32'hFFFF_FFFF, '0, '0);
        wait_idle(4);
        write_register(CFG_RATE, 16'd32768);
        send_item(MODE_READ, 32'hABCD_0123, '0, '0);
        wait_idle(4);
    endtask

    task automatic test_tick_flag();
        write_register(CFG_UPDATE, 16'd1);
        write_register(CFG_RATE, 16'd0);
        repeat (2) send_item(MODE_TICK, '0, '0, '0);
        wait_idle(4);
        write_register(CFG_RATE, 16'd10);
        repeat (5) send_item(MODE_TICK, '0, '0, '0);
        wait_idle(4);
        // rate lowered below the running count
        write_register(CFG_RATE, 16'd3);
        repeat (3) send_item(MODE_TICK, '0, '0, '0);
        wait_idle(4);
        write_register(CFG_UPDATE, 16'd0);
    endtask

    // set, then the counter runs on with reads, ticks and overflows at each wrap
    task automatic run_time_sequence();
        logic [CNT_W-1:0] hw_cnt;
        logic [63:0] step;
        logic [32:0] ahead;
        int ops;
        int pick;
        hw_cnt = $urandom;
        send_item(MODE_SET, hw_cnt, rand_seconds(), rand_nanoseconds());
        ops = $urandom_range(1, 12);
        repeat (ops) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                case ($urandom_range(0, 3))
                    0: step = 64'($urandom_range(0, 3));
                    1: step = 64'($urandom_range(0, 4 * 32768));
                    2: step = 64'($urandom);
                    default: step = 64'($urandom_range(0, 1 << 24));
                endcase
                ahead = {1'b0, hw_cnt} + step[32:0];
                if (ahead[32]) begin
                    send_item(MODE_OVERFLOW, hw_cnt, '0, '0);
                end
                hw_cnt = ahead[31:0];
                send_item(MODE_READ, hw_cnt, '0, '0);
            end else if (pick < 17) begin
                send_item(MODE_TICK, $urandom, rand_seconds(), rand_nanoseconds());
            end else if (pick < 19) begin
                send_item(MODE_READ, hw_cnt, '0, '0);
            end else begin
                send_item(MODE_OVERFLOW, hw_cnt, '0, '0);
                hw_cnt = $urandom_range(0, 1000);
            end
        end
    endtask

    task automatic test_random_sequences();
        logic [RATE_W-1:0] rate;
        int phase_end;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 6))
                0: rate = 16'd0;
                1: rate = 16'd1;
                2: rate = 16'd32768;
                3: rate = 16'hFFFF;
                4: rate = RATE_W'($urandom_range(2, 16));
                default: rate = RATE_W'($urandom_range(1, 32768));
            endcase
            write_register(CFG_RATE, rate);
            write_register(CFG_UPDATE, RATE_W'($urandom_range(0, 1)));
            phase_end = items_sent + $urandom_range(100, 250);
            if (phase_end > ITEM_TARGET) begin
                phase_end = ITEM_TARGET;
            end
            while (items_sent < phase_end) begin
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
                if ($urandom_range(0, 6) != 0) begin
                    run_time_sequence();
                end else begin
                    // noise: any mode with any field values
                    repeat ($urandom_range(1, 4)) begin
                        send_item(mode_t'($urandom_range(0, 3)), $urandom,
                                  rand_seconds(), NS_W'($urandom));
                    end
                end
            end
            wait_idle(4);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_output_stall();
        write_register(CFG_UPDATE, 16'd1);
        write_register(CFG_RATE, 16'd2);
        tx_idle = 1'b0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (STALL_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end
            repeat (12) begin
                send_item(mode_t'($urandom_range(0, 3)), $urandom,
                          rand_seconds(), rand_nanoseconds());
            end
        join
        tx_idle = 1'b1;
        wait_idle(4);
    endtask

    // result side: draws a wait after every item taken, plus the long hold-off
    always @(negedge aclk) begin
        if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && !rx_hold;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            rx_wait = rx_idle ? $urandom_range(0, 12) : 0;
            if (m_second_elapsed) flags_seen++;
            if (pending_times.size() == 0) begin
                errors++;
                $display("%0t: result item with none pending: sec %h ns %0d flag %b",
                         $time, m_time_seconds, m_time_nanoseconds, m_second_elapsed);
            end else begin
                want = pending_times.pop_front();
                if (m_time_seconds !== want.seconds) begin
                    errors++;
                    $display("%0t: time_seconds expected %h got %h",
                             $time, want.seconds, m_time_seconds);
                end
                if (m_time_nanoseconds !== want.nanoseconds) begin
                    errors++;
                    $display("%0t: time_nanoseconds expected %0d got %0d",
                             $time, want.nanoseconds, m_time_nanoseconds);
                end
                if (m_second_elapsed !== want.second_elapsed) begin
                    errors++;
                    $display("%0t: second_elapsed expected %b got %b",
                             $time, want.second_elapsed, m_second_elapsed);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, pending_times.size());
            $display("rtc_counter_time_extend_unit test failed");
            $finish;
        end
    end

    initial begin
        aclk              = 1'b0;
        aresetn           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_RATE;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_mode            = MODE_SET;
        s_counter_value   = '0;
        s_set_seconds     = '0;
        s_set_nanoseconds = '0;
        m_ready           = 1'b0;
        rate_reg          = RATE_RESET;
        update_en         = 1'b0;
        base_sec          = '0;
        base_ns           = '0;
        snapshot          = '0;
        wrapped           = 1'b0;
        tick_cnt          = '0;
        errors            = 0;
        items_sent        = 0;
        results_checked   = 0;
        cfg_writes        = 0;
        flags_seen        = 0;
        mode_count        = '{0, 0, 0, 0};
        cycle_count       = 0;
        rx_wait           = 0;
        rx_hold           = 1'b0;
        rx_idle           = 1'b1;
        tx_idle           = 1'b1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_time_set_and_read();
        test_rate_extremes();
        test_tick_flag();
        test_output_stall();
        test_random_sequences();

        wait_idle(END_SETTLE);
        $display("ran %0d items (set %0d, read %0d, overflow %0d, tick %0d), %0d results compared",
                 items_sent, mode_count[MODE_SET], mode_count[MODE_READ],
                 mode_count[MODE_OVERFLOW], mode_count[MODE_TICK], results_checked);
        $display("%0d register writes over rates 0 to 65535, %0d second flags, %0d mismatches",
                 cfg_writes, flags_seen, errors);
        if (errors == 0) begin
            $display("rtc_counter_time_extend_unit test passed");
        end else begin
            $display("rtc_counter_time_extend_unit test failed");
        end
        $finish;
    end

endmodule
